// File: hw/rtl/sclex_pkg.sv
`default_nettype none
package sclex_pkg;

    localparam int CfgIndexWidth = 2;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_SPLIT_STRINGS = 2'd0,
        REG_DROP_COMMENTS = 2'd1
    } t_reg_index;

    typedef enum logic [2:0] {
        MODE_CODE  = 3'd0,
        MODE_LINE  = 3'd1,
        MODE_BLOCK = 3'd2,
        MODE_DQ    = 3'd3,
        MODE_SQ    = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        KIND_CODE    = 2'd0,
        KIND_COMMENT = 2'd1,
        KIND_STRING  = 2'd2
    } t_kind;

    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;

    typedef struct packed {
        t_mode mode;
        logic  star_seen;
        logic  new_chunk_pending;
        logic  opener_skip;
    } t_lex_state;

    localparam t_lex_state LEX_STATE_RESET = '{
        mode: MODE_CODE, star_seen: 1'b0, new_chunk_pending: 1'b1, opener_skip: 1'b0
    };

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      byte_kind;
        logic       chunk_start;
        logic       text_end;
    } t_result;

    typedef struct packed {
        t_lex_state st;
        logic       emit;
        t_result    res;
    } t_step;

    // Classify one byte with one byte of lookahead.
    function automatic t_step lex_classify(
        input t_lex_state s,
        input logic       split,
        input logic       drop,
        input logic [7:0] b,
        input logic       has_next,
        input logic [7:0] nx
    );
        t_step      r;
        t_kind      kind;
        logic       opening;
        logic       closing;
        logic       in_cs;
        logic [7:0] quote;
        r       = '0;
        r.st    = s;
        kind    = KIND_CODE;
        opening = 1'b0;
        closing = 1'b0;
        in_cs   = (s.mode != MODE_LINE) && (s.mode != MODE_BLOCK);
        quote   = (s.mode == MODE_DQ) ? CH_DQUOTE : CH_SQUOTE;
        if (s.opener_skip) begin
            r.st.opener_skip = 1'b0;
            r.st.star_seen   = 1'b0;
            kind             = KIND_COMMENT;
        end else if (in_cs && b == CH_SLASH && has_next && (nx == CH_SLASH || nx == CH_STAR)) begin
            r.st.mode        = (nx == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
            r.st.opener_skip = 1'b1;
            r.st.star_seen   = 1'b0;
            kind             = KIND_COMMENT;
            opening          = 1'b1;
        end else begin
            case (s.mode) inside
                MODE_DQ, MODE_SQ: begin
                    kind = KIND_STRING;
                    if (b == quote) begin
                        r.st.mode = MODE_CODE;
                        closing   = 1'b1;
                    end
                end
                MODE_LINE: begin
                    kind = KIND_COMMENT;
                    if (b == CH_NEWLINE) begin
                        r.st.mode = MODE_CODE;
                        closing   = 1'b1;
                    end
                end
                MODE_BLOCK: begin
                    kind = KIND_COMMENT;
                    if (s.star_seen && b == CH_SLASH) begin
                        r.st.mode      = MODE_CODE;
                        r.st.star_seen = 1'b0;
                        closing        = 1'b1;
                    end else begin
                        r.st.star_seen = (b == CH_STAR);
                    end
                end
                default: begin
                    // unused mode codes behave as code
                    r.st.mode = MODE_CODE;
                    if (split && (b == CH_DQUOTE || b == CH_SQUOTE)) begin
                        r.st.mode = (b == CH_DQUOTE) ? MODE_DQ : MODE_SQ;
                        kind      = KIND_STRING;
                        opening   = 1'b1;
                    end
                end
            endcase
        end
        r.res.out_byte         = b;
        r.res.byte_kind        = kind;
        r.res.chunk_start      = s.new_chunk_pending || opening;
        r.res.text_end         = 1'b0;
        r.st.new_chunk_pending = closing;
        r.emit                 = !(kind == KIND_COMMENT && drop);
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/source_comment_string_lexer.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_ready         i_text_byte, i_final_byte
// result    out        o_valid / i_ready         o_out_byte, o_byte_kind,
//                                                o_chunk_start, o_text_end
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One byte per cycle while o_ready is high; results of a taken request are registered.
// Each byte is classified when the following byte arrives, so output lags by one
// byte; the final byte flushes both, which can queue two results.
// A four-entry result queue decouples the sides; o_ready drops while fewer than
// two entries are free, so a stalled consumer stops input before the queue overflows.
// Synchronous active-low reset clears lexer state, queue and registers; no sweep.
`default_nettype none
module source_comment_string_lexer
    import sclex_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire  [7:0]               i_text_byte,
    input  wire                      i_final_byte,
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic [7:0]               o_out_byte,
    output logic [1:0]               o_byte_kind,
    output logic                     o_chunk_start,
    output logic                     o_text_end,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire  [CfgIndexWidth-1:0] i_cfg_index,
    input  wire                      i_cfg_data
);

    logic       r_split;
    logic       r_drop;
    t_lex_state r_st;
    logic [7:0] r_held_byte;
    logic       r_held_valid;

    t_result    r_q [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;

    t_step      step_held;
    t_step      step_fin;
    t_lex_state st_mid;
    logic       emit_held;
    logic       emit_fin;
    t_result    res_held;
    t_result    res_fin;
    logic       in_fire;
    logic       out_fire;
    logic [1:0] n_push;
    logic [1:0] wr_ptr_2nd;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_count <= 3'd2);
    assign in_fire     = i_valid && o_ready;
    assign o_valid     = (r_count != 3'd0);
    assign out_fire    = o_valid && i_ready;

    always_comb begin
        step_held = lex_classify(r_st, r_split, r_drop, r_held_byte, 1'b1, i_text_byte);
        st_mid    = r_held_valid ? step_held.st : r_st;
        emit_held = r_held_valid && step_held.emit;
        step_fin  = lex_classify(st_mid, r_split, r_drop, i_text_byte, 1'b0, 8'h00);
        emit_fin  = i_final_byte && step_fin.emit;
        res_held  = step_held.res;
        res_fin   = step_fin.res;
        // text_end goes on whichever result of the final request comes last
        if (i_final_byte) begin
            if (emit_fin) begin
                res_fin.text_end = 1'b1;
            end else begin
                res_held.text_end = 1'b1;
            end
        end
        n_push     = in_fire ? ({1'b0, emit_held} + {1'b0, emit_fin}) : 2'd0;
        wr_ptr_2nd = r_wr_ptr + {1'b0, emit_held};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split      <= 1'b0;
            r_drop       <= 1'b0;
            r_st         <= LEX_STATE_RESET;
            r_held_byte  <= 8'h00;
            r_held_valid <= 1'b0;
            r_wr_ptr     <= 2'd0;
            r_rd_ptr     <= 2'd0;
            r_count      <= 3'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_SPLIT_STRINGS: r_split <= i_cfg_data;
                    REG_DROP_COMMENTS: r_drop  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_fire) begin
                if (i_final_byte) begin
                    r_st         <= LEX_STATE_RESET;
                    r_held_byte  <= 8'h00;
                    r_held_valid <= 1'b0;
                end else begin
                    r_st         <= st_mid;
                    r_held_byte  <= i_text_byte;
                    r_held_valid <= 1'b1;
                end
            end
            r_wr_ptr <= r_wr_ptr + n_push;
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + {1'b0, n_push} - {2'b00, out_fire};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && emit_held) begin
            r_q[r_wr_ptr] <= res_held;
        end
        if (in_fire && emit_fin) begin
            r_q[wr_ptr_2nd] <= res_fin;
        end
    end

    assign o_out_byte    = r_q[r_rd_ptr].out_byte;
    assign o_byte_kind   = r_q[r_rd_ptr].byte_kind;
    assign o_chunk_start = r_q[r_rd_ptr].chunk_start;
    assign o_text_end    = r_q[r_rd_ptr].text_end;

endmodule
`default_nettype wire

// File: hw/rtl/sclex_checker.sv
`default_nettype none
module sclex_checker
    import sclex_pkg::*;
(
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     o_ready,
    input wire                     o_valid,
    input wire                     i_ready,
    input wire [7:0]               o_out_byte,
    input wire [1:0]               o_byte_kind,
    input wire                     o_chunk_start,
    input wire                     o_text_end
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_byte_kind)
            && $stable(o_chunk_start) && $stable(o_text_end))
        else $error("result changed while stalled");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_byte_kind == KIND_CODE || o_byte_kind == KIND_COMMENT
            || o_byte_kind == KIND_STRING))
        else $error("undefined byte kind");

    // input backpressure only comes from queued results
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with empty result queue");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("results present after reset");

endmodule

bind source_comment_string_lexer sclex_checker u_sclex_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_out_byte    (o_out_byte),
    .o_byte_kind   (o_byte_kind),
    .o_chunk_start (o_chunk_start),
    .o_text_end    (o_text_end)
);
`default_nettype wire
